>>> rtl/core/q97dc_pkg.sv
// Shared types and constants for the Q9.7 to decimal converter.
// Used by q97dc_cell and q9_7_to_decimal_converter; depends on nothing.

package q97dc_pkg;

  localparam int unsigned ValueWidth = 16;
  localparam int unsigned DecWidth   = 2;
  localparam int unsigned ShiftWidth = 3;

  // Binary fraction bits of Q9.7 and the largest supported decimal count.
  localparam logic [ShiftWidth-1:0] QFracBits   = 3'd7;
  localparam logic [2:0]            MaxDecimals = 3'd2;

  // One cell per round: seven shifts plus one round for trailing multiplies.
  localparam int unsigned NumCells = 8;

  // Multiply by five only while the magnitude stays strictly below this.
  localparam logic signed [ValueWidth-1:0] MulLimit = 16'sd6553;

  localparam logic signed [ValueWidth-1:0] SatHigh = 16'sh7FFF;
  localparam logic signed [ValueWidth-1:0] SatLow  = 16'sh8000;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic [DecWidth-1:0]          dec;     // multiplies by five still owed
    logic [ShiftWidth-1:0]        shifts;  // right shifts still owed
  } stage_t;

endpackage

>>> rtl/core/q9_7_to_decimal_converter.sv
// Top level of the Q9.7 to decimal converter: input decode and a chain of
// eight q97dc_cell rounds. Uses q97dc_pkg and q97dc_cell.

// Converts a signed Q9.7 temperature to an integer scaled by ten to the
// requested number of decimal places (0 to 2), as value * 5^d / 2^(7-d) with
// multiplies by five interleaved before arithmetic right shifts. Inputs 32767
// and -32768 pass through unchanged; more than two decimals returns 32767.
// One transaction is accepted per cycle while the first cell is ready. The
// first cell registers a transaction at its accepting edge and each further
// cell registers it in turn through all eight cells. The last cell's
// register holds the result, and back-pressure ripples through the chain
// so empty cells keep filling while the output is stalled.

module q9_7_to_decimal_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] fixed_value_i,
  input  logic [2:0]         decimal_places_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] decimal_value_o
);

  localparam int unsigned NumCells = q97dc_pkg::NumCells;

  q97dc_pkg::stage_t chain_data  [NumCells+1];
  logic              chain_valid [NumCells+1];
  logic              chain_ready [NumCells+1];

  // Saturation marks and unsupported decimal counts skip all work.
  always_comb begin
    chain_data[0].value  = fixed_value_i;
    chain_data[0].dec    = '0;
    chain_data[0].shifts = '0;
    if (decimal_places_i > q97dc_pkg::MaxDecimals) begin
      chain_data[0].value = q97dc_pkg::SatHigh;
    end else if (fixed_value_i != q97dc_pkg::SatHigh && fixed_value_i != q97dc_pkg::SatLow) begin
      chain_data[0].dec    = decimal_places_i[q97dc_pkg::DecWidth-1:0];
      chain_data[0].shifts = q97dc_pkg::QFracBits - decimal_places_i;
    end
  end

  assign chain_valid[0] = in_valid_i;
  assign in_ready_o     = chain_ready[0];

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    q97dc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  assign chain_ready[NumCells] = out_ready_i;
  assign out_valid_o           = chain_valid[NumCells];
  assign decimal_value_o       = chain_data[NumCells].value;

endmodule

>>> rtl/core/q97dc_cell.sv
// One round of the scaling chain: up to two multiplies by five, then at most one
// arithmetic right shift, with an elastic valid/ready register. Uses q97dc_pkg.

module q97dc_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  q97dc_pkg::stage_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output q97dc_pkg::stage_t data_o
);

  logic              valid_q;
  q97dc_pkg::stage_t data_q;
  q97dc_pkg::stage_t mul1;
  q97dc_pkg::stage_t mul2;
  q97dc_pkg::stage_t data_d;

  function automatic q97dc_pkg::stage_t mul_step(input q97dc_pkg::stage_t s);
    q97dc_pkg::stage_t r;
    r = s;
    if (s.dec != '0 && s.value < q97dc_pkg::MulLimit && s.value > -q97dc_pkg::MulLimit) begin
      r.value = (s.value <<< 2) + s.value;
      r.dec   = s.dec - 2'd1;
    end
    return r;
  endfunction

  always_comb begin
    mul1   = mul_step(data_i);
    mul2   = mul_step(mul1);
    data_d = mul2;
    if (mul2.shifts != '0) begin
      data_d.value  = mul2.value >>> 1;
      data_d.shifts = mul2.shifts - 3'd1;
    end
  end

  // Take a new transaction when empty or when the current one moves on.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
